// File: rtl/core/mpma_pkg.sv
`timescale 1ns / 1ps

package mpma_pkg;

  // field widths
  localparam int RAW_W     = 16;
  localparam int GAIN_W    = 20;
  localparam int PCT_W     = 15;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_W     = 20;

  // 100 % in Q7.8
  localparam logic [PCT_W-1:0] FULL_SCALE = PCT_W'(25600);

  // register reset values
  localparam logic [RAW_W-1:0]  DRY_RESET  = RAW_W'(57000);
  localparam logic [GAIN_W-1:0] GAIN_RESET = GAIN_W'(83886);

  // default averaging window
  localparam int WINDOW_DEF = 10;

  // register map
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DRY_CODE = 1'b0,
    CFG_GAIN     = 1'b1
  } cfg_idx_t;

  // calibration settings
  typedef struct packed {
    logic [RAW_W-1:0]  dry_code;
    logic [GAIN_W-1:0] gain;
  } cfg_t;

  // pipeline controls into the window stage
  typedef struct packed {
    logic load;     // item moves from input register into ring-read stage
    logic advance;  // item moves from ring-read stage into sum stage
  } win_ctl_t;

endpackage

// File: rtl/core/mpma_if.sv
`timescale 1ns / 1ps

// input beat: one converter reading
interface mpma_in_if;
  import mpma_pkg::*;

  logic             valid;
  logic             ready;
  logic [RAW_W-1:0] raw_sample;

  modport source (output valid, output raw_sample, input ready);
  modport sink   (input valid, input raw_sample, output ready);
endinterface

// result beat: sample and window mean
interface mpma_out_if;
  import mpma_pkg::*;

  logic             valid;
  logic             ready;
  logic [PCT_W-1:0] sample_percent;
  logic [PCT_W-1:0] average_percent;

  modport source (output valid, output sample_percent, output average_percent, input ready);
  modport sink   (input valid, input sample_percent, input average_percent, output ready);
endinterface

// File: rtl/core/moisture_percent_moving_average.sv
`timescale 1ns / 1ps

// Soil-moisture percentage with a moving average. Each input beat carries one
// 16-bit converter reading; the block turns it into unsigned Q7.8 percent as
// (dry_code - raw_sample) * gain / 2^16, clamped to 0..25600 (100 %), and
// returns that value with the mean of the last WINDOW clamped values (slots
// not yet filled count as zero). One beat is accepted every clock cycle while
// the pipeline is not stalled. Each result passes through the input register,
// the ring read (the ring memory has a registered read port), running-total
// update, and the reciprocal-multiply divide into the output register. Each
// stage stalls only when the stage after it is full, so bubbles are squeezed
// out under back-pressure. Reset clears the running total and the ring valid
// bits at once, so no clearing pass is needed. Write dry_code (index 0) and
// gain (index 1) only while no beat is in flight.
module moisture_percent_moving_average #(
  parameter int WINDOW = mpma_pkg::WINDOW_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  mpma_in_if.sink                        in_ch,
  mpma_out_if.source                     out_ch,
  input  logic                           cfg_we,
  input  logic [mpma_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [mpma_pkg::CFG_W-1:0]     cfg_wdata
);
  import mpma_pkg::*;

  localparam int TOTAL_W = $clog2(FULL_SCALE * WINDOW + 1);

  cfg_t               cfg;
  win_ctl_t           win_ctl;
  logic               v0_r, v1_r, v2_r, vo_r;
  logic               v0_nxt, v1_nxt, v2_nxt, vo_nxt;
  logic               rdy0, rdy1, rdy2, rdy_o;
  logic [RAW_W-1:0]   raw_s0_r;
  logic [PCT_W-1:0]   pct_s0;
  logic [PCT_W-1:0]   pct_s2;
  logic [TOTAL_W-1:0] sum_s2;
  logic [PCT_W-1:0]   mean_s2;
  logic [PCT_W-1:0]   sample_pct_r;
  logic [PCT_W-1:0]   average_pct_r;

  mpma_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  mpma_scale u_scale (
    .cfg        (cfg),
    .raw_sample (raw_s0_r),
    .pct        (pct_s0)
  );

  mpma_window #(
    .WINDOW (WINDOW)
  ) u_window (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (win_ctl),
    .pct_in  (pct_s0),
    .pct_out (pct_s2),
    .sum_out (sum_s2)
  );

  mpma_mean #(
    .WINDOW (WINDOW)
  ) u_mean (
    .sum  (sum_s2),
    .mean (mean_s2)
  );

  // per-stage ready: a stage takes a beat when empty or when it moves on
  assign rdy_o = !vo_r || out_ch.ready;
  assign rdy2  = !v2_r || rdy_o;
  assign rdy1  = !v1_r || rdy2;
  assign rdy0  = !v0_r || rdy1;

  assign win_ctl.load    = v0_r && rdy1;
  assign win_ctl.advance = v1_r && rdy2;

  always_comb begin
    v0_nxt = rdy0  ? in_ch.valid : v0_r;
    v1_nxt = rdy1  ? v0_r        : v1_r;
    v2_nxt = rdy2  ? v1_r        : v2_r;
    vo_nxt = rdy_o ? v2_r        : vo_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      vo_r <= 1'b0;
    end else begin
      v0_r <= v0_nxt;
      v1_r <= v1_nxt;
      v2_r <= v2_nxt;
      vo_r <= vo_nxt;
    end
  end

  // input and output payload registers
  always_ff @(posedge clk) begin
    if (in_ch.valid && rdy0) begin
      raw_s0_r <= in_ch.raw_sample;
    end
    if (v2_r && rdy_o) begin
      sample_pct_r  <= pct_s2;
      average_pct_r <= mean_s2;
    end
  end

  assign in_ch.ready            = rdy0;
  assign out_ch.valid           = vo_r;
  assign out_ch.sample_percent  = sample_pct_r;
  assign out_ch.average_percent = average_pct_r;

endmodule

// File: rtl/core/mpma_ram.sv
`timescale 1ns / 1ps

module mpma_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// File: rtl/core/mpma_cfg.sv
`timescale 1ns / 1ps

module mpma_cfg (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [mpma_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [mpma_pkg::CFG_W-1:0]     cfg_wdata,
  output mpma_pkg::cfg_t                 cfg
);
  import mpma_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  // register decode
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_DRY_CODE: cfg_nxt.dry_code = cfg_wdata[RAW_W-1:0];
        CFG_GAIN:     cfg_nxt.gain     = cfg_wdata[GAIN_W-1:0];
        default:      cfg_nxt          = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.dry_code <= DRY_RESET;
      cfg_r.gain     <= GAIN_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// File: rtl/core/mpma_scale.sv
`timescale 1ns / 1ps

// Linear calibration: (dry - raw) * gain >> 16, clamped to 100 %
module mpma_scale (
  input  mpma_pkg::cfg_t                 cfg,
  input  logic [mpma_pkg::RAW_W-1:0]     raw_sample,
  output logic [mpma_pkg::PCT_W-1:0]     pct
);
  import mpma_pkg::*;

  localparam int PROD_W = RAW_W + GAIN_W;
  localparam int FRAC_W = 16;

  logic [RAW_W:0]           diff;
  logic [PROD_W-1:0]        prod;
  logic [PROD_W-FRAC_W-1:0] scaled;

  always_comb begin
    diff   = {1'b0, cfg.dry_code} - {1'b0, raw_sample};
    prod   = PROD_W'(diff[RAW_W-1:0]) * PROD_W'(cfg.gain);
    scaled = prod[PROD_W-1:FRAC_W];
    // at or above the dry point reads as dry soil
    if (raw_sample >= cfg.dry_code) begin
      pct = '0;
    end else if (scaled > (PROD_W-FRAC_W)'(FULL_SCALE)) begin
      pct = FULL_SCALE;
    end else begin
      pct = scaled[PCT_W-1:0];
    end
  end

endmodule

// File: rtl/core/mpma_window.sv
`timescale 1ns / 1ps

// Ring of recent samples and running total. Two stages: ring read, then sum.
module mpma_window #(
  parameter int WINDOW = mpma_pkg::WINDOW_DEF
) (
  input  logic                                                 clk,
  input  logic                                                 rst_n,
  input  mpma_pkg::win_ctl_t                                   ctl,
  input  logic [mpma_pkg::PCT_W-1:0]                           pct_in,
  output logic [mpma_pkg::PCT_W-1:0]                           pct_out,
  output logic [$clog2(mpma_pkg::FULL_SCALE * WINDOW + 1)-1:0] sum_out
);
  import mpma_pkg::*;

  localparam int SLOT_W  = $clog2(WINDOW);
  localparam int TOTAL_W = $clog2(FULL_SCALE * WINDOW + 1);
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(WINDOW - 1);

  logic [SLOT_W-1:0]  rd_slot_r, rd_slot_nxt;
  logic [SLOT_W-1:0]  wr_slot_r, wr_slot_nxt;
  logic [WINDOW-1:0]  ring_vld_r, ring_vld_nxt;
  logic [TOTAL_W-1:0] total_r, total_nxt;
  logic               old_vld_r;
  logic [PCT_W-1:0]   pct_s1_r;
  logic [PCT_W-1:0]   pct_s2_r;
  logic [TOTAL_W-1:0] sum_s2_r;
  logic [PCT_W-1:0]   ram_rd_data;
  logic [PCT_W-1:0]   old_pct;

  // ring storage; read on load, written on advance
  mpma_ram #(
    .WIDTH (PCT_W),
    .DEPTH (WINDOW)
  ) u_ring (
    .clk     (clk),
    .wr_en   (ctl.advance),
    .wr_addr (wr_slot_r),
    .wr_data (pct_s1_r),
    .rd_en   (ctl.load),
    .rd_addr (rd_slot_r),
    .rd_data (ram_rd_data)
  );

  // never-written entries count as zero
  assign old_pct = old_vld_r ? ram_rd_data : '0;

  always_comb begin
    rd_slot_nxt  = rd_slot_r;
    wr_slot_nxt  = wr_slot_r;
    ring_vld_nxt = ring_vld_r;
    total_nxt    = total_r;
    if (ctl.load) begin
      rd_slot_nxt = (rd_slot_r == LAST_SLOT) ? '0 : rd_slot_r + 1'b1;
    end
    if (ctl.advance) begin
      wr_slot_nxt             = (wr_slot_r == LAST_SLOT) ? '0 : wr_slot_r + 1'b1;
      ring_vld_nxt[wr_slot_r] = 1'b1;
      total_nxt               = total_r - TOTAL_W'(old_pct) + TOTAL_W'(pct_s1_r);
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_slot_r  <= '0;
      wr_slot_r  <= '0;
      ring_vld_r <= '0;
      total_r    <= '0;
    end else begin
      rd_slot_r  <= rd_slot_nxt;
      wr_slot_r  <= wr_slot_nxt;
      ring_vld_r <= ring_vld_nxt;
      total_r    <= total_nxt;
    end
  end

  // stage payloads
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      pct_s1_r  <= pct_in;
      old_vld_r <= ring_vld_r[rd_slot_r];
    end
    if (ctl.advance) begin
      pct_s2_r <= pct_s1_r;
      sum_s2_r <= total_nxt;
    end
  end

  assign pct_out = pct_s2_r;
  assign sum_out = sum_s2_r;

endmodule

// File: rtl/core/mpma_mean.sv
`timescale 1ns / 1ps

// Total / WINDOW by reciprocal multiply; exact for every total below 2^TOTAL_W
module mpma_mean #(
  parameter int WINDOW = mpma_pkg::WINDOW_DEF
) (
  input  logic [$clog2(mpma_pkg::FULL_SCALE * WINDOW + 1)-1:0] sum,
  output logic [mpma_pkg::PCT_W-1:0]                           mean
);
  import mpma_pkg::*;

  localparam int TOTAL_W = $clog2(FULL_SCALE * WINDOW + 1);
  localparam int SHIFT   = TOTAL_W + $clog2(WINDOW);
  localparam longint unsigned RECIP = ((64'd1 << SHIFT) + WINDOW - 1) / WINDOW;
  localparam int RECIP_W = $clog2(RECIP + 1);
  localparam int PROD_W  = TOTAL_W + RECIP_W;

  logic [PROD_W-1:0] prod;

  assign prod = PROD_W'(sum) * PROD_W'(RECIP);
  assign mean = prod[SHIFT +: PCT_W];

endmodule

// File: tb/moisture_checker.sv
`timescale 1ns / 1ps

// Watches both channels and the calibration port, keeps its own copy of the
// calibration, the averaging ring and the running total, and compares every
// result beat against the oldest prediction.
module moisture_checker #(
  parameter int WINDOW = mpma_pkg::WINDOW_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  mpma_in_if                             in_mon,
  mpma_out_if                            out_mon,
  input  logic                           cfg_we,
  input  logic [mpma_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [mpma_pkg::CFG_W-1:0]     cfg_wdata,
  output int                             mismatches,
  output int                             beats_in_flight
);
  import mpma_pkg::*;

  localparam int TOTAL_W = PCT_W + $clog2(WINDOW) + 1;

  typedef struct packed {
    logic [PCT_W-1:0] sample;
    logic [PCT_W-1:0] average;
  } moisture_pair_t;

  logic [RAW_W-1:0]   dry_code;
  logic [GAIN_W-1:0]  gain;
  logic [PCT_W-1:0]   ring [WINDOW];
  int                 slot;
  logic [TOTAL_W-1:0] total;
  moisture_pair_t     awaited_moisture [$];

  // linear calibration, truncated, then saturated at 100 %
  function automatic logic [PCT_W-1:0] calibrate_reading(logic [RAW_W-1:0]  raw,
                                                          logic [RAW_W-1:0]  dry,
                                                          logic [GAIN_W-1:0] g);
    logic [RAW_W+GAIN_W-1:0] product;
    if (raw >= dry) return '0;
    product = (dry - raw) * g;
    product = product >> 16;
    if (product > FULL_SCALE) return FULL_SCALE;
    return product[PCT_W-1:0];
  endfunction

  always @(posedge clk) begin : monitor
    logic [PCT_W-1:0] pct;
    moisture_pair_t   want;
    if (!rst_n) begin
      dry_code = DRY_RESET;
      gain     = GAIN_RESET;
      for (int i = 0; i < WINDOW; i++) ring[i] = '0;
      slot  = 0;
      total = '0;
      awaited_moisture.delete();
    end else begin
      // calibration writes
      if (cfg_we) begin
        case (cfg_idx_t'(cfg_index))
          CFG_DRY_CODE: dry_code = cfg_wdata[RAW_W-1:0];
          CFG_GAIN:     gain = cfg_wdata[GAIN_W-1:0];
          default: ;
        endcase
      end

      // accepted reading: update ring and total, queue the prediction
      if (in_mon.valid && in_mon.ready) begin
        pct = calibrate_reading(in_mon.raw_sample, dry_code, gain);
        total = total - ring[slot] + pct;
        ring[slot] = pct;
        slot = (slot == WINDOW - 1) ? 0 : slot + 1;
        want.sample  = pct;
        want.average = PCT_W'(total / WINDOW);
        awaited_moisture.push_back(want);
      end

      // accepted result: compare with the oldest prediction
      if (out_mon.valid && out_mon.ready) begin
        if (awaited_moisture.size() == 0) begin
          $display("%0t: unexpected result beat, sample_percent %0d average_percent %0d",
                   $time, out_mon.sample_percent, out_mon.average_percent);
          mismatches++;
        end else begin
          want = awaited_moisture.pop_front();
          if (out_mon.sample_percent !== want.sample) begin
            $display("%0t: sample_percent expected %0d, got %0d",
                     $time, want.sample, out_mon.sample_percent);
            mismatches++;
          end
          if (out_mon.average_percent !== want.average) begin
            $display("%0t: average_percent expected %0d, got %0d",
                     $time, want.average, out_mon.average_percent);
            mismatches++;
          end
        end
      end
    end
    beats_in_flight = awaited_moisture.size();
  end

endmodule

// File: tb/tb.sv
`timescale 1ns / 1ps

module tb;
  import mpma_pkg::*;

  localparam int WINDOW  = WINDOW_DEF;
  localparam int LATENCY = 4;
  localparam int PHASES  = 9;

  logic                 clk       = 1'b0;
  logic                 rst_n     = 1'b0;
  logic                 cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_wdata = '0;
  int                   mismatches;
  int                   beats_in_flight;
  int unsigned          cur_dry;
  int unsigned          cur_gain;

  // readings around the zero and the full-scale knee of the reset calibration
  logic [RAW_W-1:0] reset_cal_readings [17] = '{
    16'd0, 16'd65535, 16'd57000, 16'd56999, 16'd57001, 16'd37000, 16'd36999,
    16'd37001, 16'd36990, 16'd50000, 16'd1, 16'd32768, 16'd65534, 16'd20000,
    16'd45000, 16'd12345, 16'd57000
  };
  // same for the steepest calibration, knee at 1600 counts below 65535
  logic [RAW_W-1:0] max_cal_readings [6] = '{
    16'd0, 16'd65535, 16'd65534, 16'd63935, 16'd63936, 16'd63934
  };

  mpma_in_if  in_ch ();
  mpma_out_if out_ch ();

  moisture_percent_moving_average #(
    .WINDOW(WINDOW)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  moisture_checker #(
    .WINDOW(WINDOW)
  ) u_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_mon         (in_ch),
    .out_mon        (out_ch),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .mismatches     (mismatches),
    .beats_in_flight(beats_in_flight)
  );

  // 4 ns clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // idle gap: mostly none or short, now and then long
  function automatic int pick_gap(bit calm);
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // reading: full range, near the dry point, near the clamp knee, extremes, small codes
  function automatic logic [RAW_W-1:0] pick_reading(int unsigned dry, int unsigned g);
    longint unsigned knee;
    longint          v;
    int              jitter;
    jitter = int'($urandom_range(0, 64)) - 32;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return RAW_W'($urandom);
      4, 5: v = longint'(dry) + longint'(jitter);
      6, 7: begin
        if (g == 0) return RAW_W'($urandom);
        knee = (64'd25600 << 16) / g;
        v = longint'(dry) - longint'(knee) + longint'(jitter);
      end
      8: return ($urandom_range(0, 1) != 0) ? '1 : '0;
      default: return RAW_W'($urandom_range(0, 255));
    endcase
    if (v < 0) v = 0;
    else if (v > 65535) v = 65535;
    return RAW_W'(v);
  endfunction

  // one input beat after an optional gap; returns at the accepting edge
  task automatic send_reading(input logic [RAW_W-1:0] raw, input int gap);
    bit took;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.raw_sample <= raw;
    do begin
      @(negedge clk);
      took = in_ch.ready;
      @(posedge clk);
    end while (!took);
  endtask

  // stop sending and wait for every predicted beat, plus pipeline slack
  task automatic drain();
    in_ch.valid <= 1'b0;
    do @(negedge clk); while (beats_in_flight != 0);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  // both calibration registers, back to back
  task automatic write_calibration(input int unsigned dry, input int unsigned g);
    cur_dry  = dry;
    cur_gain = g;
    cfg_we    <= 1'b1;
    cfg_index <= CFG_DRY_CODE;
    cfg_wdata <= CFG_W'(dry);
    @(posedge clk);
    cfg_index <= CFG_GAIN;
    cfg_wdata <= CFG_W'(g);
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // result side back-pressure
  initial begin : result_sink
    int hold;
    int pause;
    forever begin
      hold = ($urandom_range(0, 15) == 0) ? $urandom_range(40, 200) : $urandom_range(1, 6);
      out_ch.ready <= 1'b1;
      repeat (hold) @(posedge clk);
      pause = pick_gap(1'b0);
      if (pause > 0) begin
        out_ch.ready <= 1'b0;
        repeat (pause) @(posedge clk);
      end
    end
  end

  // stimulus and verdict
  initial begin : stimulus
    int  n;
    bit  calm;
    in_ch.valid      <= 1'b0;
    in_ch.raw_sample <= '0;
    cur_dry  = DRY_RESET;
    cur_gain = GAIN_RESET;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // directed: reset calibration, ring wraps past WINDOW
    foreach (reset_cal_readings[i])
      send_reading(reset_cal_readings[i], (i < 8) ? 0 : pick_gap(1'b0));
    drain();

    // directed: steepest calibration
    write_calibration(32'hFFFF, 32'hFFFFF);
    foreach (max_cal_readings[i]) send_reading(max_cal_readings[i], pick_gap(1'b0));
    drain();

    // random phases over several calibrations
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: write_calibration(DRY_RESET, GAIN_RESET);
        1: write_calibration(0, 0);
        2: write_calibration(32'hFFFF, 32'hFFFFF);
        3: write_calibration(32'hFFFF, 0);
        4: write_calibration(0, 32'hFFFFF);
        default: write_calibration($urandom_range(0, 65535),
                                   ($urandom_range(0, 1) != 0) ?
                                   $urandom_range(0, 32'hFFFFF) :
                                   $urandom_range(0, 200000));
      endcase
      n = (p == 1 || p == 3 || p == 4) ? 60 : 300;
      calm = 1'b0;
      for (int i = 0; i < n; i++) begin
        if ($urandom_range(0, 47) == 0) calm = !calm;
        // sender holds off until the pipeline is empty
        if (p == 0 && i == n / 2) drain();
        send_reading(pick_reading(cur_dry, cur_gain), pick_gap(calm));
      end
      drain();
    end

    @(negedge clk);
    if (mismatches == 0 && beats_in_flight == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // watchdog
  initial begin
    #4000000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule

// File: filelist.f
rtl/core/mpma_pkg.sv
rtl/core/mpma_if.sv
rtl/core/mpma_ram.sv
rtl/core/mpma_cfg.sv
rtl/core/mpma_scale.sv
rtl/core/mpma_window.sv
rtl/core/mpma_mean.sv
rtl/core/moisture_percent_moving_average.sv
tb/moisture_checker.sv
tb/tb.sv
